/* rtl/core/open_addressing_hash_table_defines.svh */
// assertion macros for the open-addressing hash table
// used by the rtl files that check their own logic; expects clk and rst_n in scope
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/oht_pkg.sv */
// shared types and constants of the open-addressing hash table
// no dependencies; imported by every module of the block
package oht_pkg;

    localparam int KEY_W     = 31;
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int PRIME_W   = 8;
    localparam int SLOT_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int SLOTS_DEF = 8;

    // remainder unit: 32-bit dividend, divisor up to 511, 4 quotient bits per cycle
    localparam int DIV_DW    = 32;
    localparam int DIV_W     = 9;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_DW / DIV_BITS;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 1'd1;

    localparam logic [PRIME_W-1:0] PRIME_RESET = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_STEP,
        ST_PROBE,
        ST_RESULT
    } oht_state_t;

    // write command from the control to the slot store
    typedef struct packed {
        logic wr_key;
        logic set_used;
        logic clr_used;
    } store_cmd_t;

endpackage

/* rtl/core/oht_mod_unit.sv */
// iterative remainder unit: dividend mod divisor, four bits per cycle
// depends on oht_pkg
module oht_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [oht_pkg::DIV_DW-1:0]  dividend,
    input  logic [oht_pkg::DIV_W-1:0]   divisor,
    output logic                        done,
    output logic [oht_pkg::DIV_W-1:0]   remainder
);
    import oht_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [DIV_DW-1:0] shift_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // restoring steps: remainder stays below divisor, so the trial fits one extra bit
    always_comb
    begin
        logic [DIV_W:0] trial;
        rem_next = rem_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial = {rem_next, shift_reg[DIV_DW-1-k]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << DIV_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/oht_store.sv */
// slot store: key memory with registered read, plus per-slot valid bits
// depends on oht_pkg
module oht_store #(
    parameter int SLOTS = oht_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [oht_pkg::KEY_W-1:0]   rd_key,
    output logic                        rd_used,
    input  oht_pkg::store_cmd_t         cmd,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [oht_pkg::KEY_W-1:0]   wr_key
);
    import oht_pkg::*;

    logic [KEY_W-1:0] keys_mem [SLOTS];
    logic [SLOTS-1:0] used_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic             rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_key)
        begin
            keys_mem[wr_addr] <= wr_key;
        end
        if (rd_en)
        begin
            rd_key_reg <= keys_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_used)
            begin
                used_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.clr_used)
            begin
                used_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_used_reg <= used_reg[rd_addr];
            end
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_used = rd_used_reg;

endmodule

/* rtl/core/open_addressing_hash_table.sv */
// open-addressing hash table: probe sequencer, configuration and stream ports
// depends on oht_pkg, oht_mod_unit, oht_store and open_addressing_hash_table_defines.svh
//
// usage:
//   s_* carries one operation per beat: op in s_tuser, key in s_tdata.
//   m_* returns one result beat per operation: success in m_tuser, slot in m_tdata.
//   cfg_* writes probe_mode (index 0) or double_hash_prime (index 1); always ready,
//   to be written only while no operation is in flight.
// timing:
//   one operation at a time; s_tready is high only while the sequencer is idle.
//   hashing: key mod double_hash_prime in the remainder unit, key mod SLOTS beside it
//   by reciprocal multiply; double hashing adds a step state for the step mod SLOTS.
//   the walk reads one slot per cycle and ends at the first hit or after SLOTS probes;
//   the result then moves to the output register, and a new operation is taken only
//   after that.
// reset:
//   all slots empty, probe_mode 0, double_hash_prime 3; no clearing pass needed.
// back pressure:
//   the result waits in the output register while m_tready is low; a finished
//   walk holds its result until that register frees up.
module open_addressing_hash_table #(
    parameter int SLOTS = oht_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,    // [30:0] key, [31] zero
    input  logic [oht_pkg::OP_W-1:0]        s_tuser,    // [1:0] op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [oht_pkg::SLOT_W-1:0]      m_tdata,    // [7:0] slot_index
    output logic                            m_tuser,    // [0] success
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [oht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [oht_pkg::CFG_W-1:0]       cfg_data
);
    import oht_pkg::*;

    `include "open_addressing_hash_table_defines.svh"

    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W    = IDX_W + 1;
    localparam int ONE_MOD  = 1 % SLOTS;
    localparam int TWO_MOD  = 2 % SLOTS;

    // key / SLOTS as (key * REC_M) >> REC_SH, exact for every 31-bit key
    localparam int              REC_SH   = KEY_W + $clog2(SLOTS);
    localparam longint unsigned REC_FULL = ((64'd1 << REC_SH) + 64'(SLOTS) - 64'd1)
                                           / 64'(SLOTS);
    localparam logic [KEY_W:0]  REC_M    = REC_FULL[KEY_W:0];

    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(SLOTS))
        begin
            s = s - SUM_W'(SLOTS);
        end
        return s[IDX_W-1:0];
    endfunction

    // constant table of v mod SLOTS for an 8-bit step
    function automatic logic [IDX_W-1:0] step_mod(input logic [PRIME_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << PRIME_W); k++)
        begin
            if (v == PRIME_W'(k))
            begin
                r = IDX_W'(k % SLOTS);
            end
        end
        return r;
    endfunction

    oht_state_t state_reg;
    oht_state_t state_next;

    logic [MODE_W-1:0]  probe_mode_reg;
    logic [PRIME_W-1:0] prime_reg;

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   quot_reg;
    logic [IDX_W-1:0]   home_reg;
    logic [IDX_W-1:0]   off_reg;
    logic [IDX_W-1:0]   inc_reg;
    logic [IDX_W-1:0]   dstep_reg;
    logic [SUM_W-1:0]   cnt_reg;
    logic               chk_reg;
    logic [IDX_W-1:0]   slot_q_reg;
    logic               res_ok_reg;
    logic [IDX_W-1:0]   res_slot_reg;

    logic               m_tvalid_reg;
    logic [SLOT_W-1:0]  m_tdata_reg;
    logic               m_tuser_reg;

    logic               in_accept;
    logic               issue;
    logic               hit;
    logic               out_load;
    logic [IDX_W-1:0]   cur_slot;
    logic [IDX_W-1:0]   term;

    logic [2*KEY_W:0]   rec_prod;
    logic [KEY_W-1:0]   home_full;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_rem;
    logic [DIV_W-1:0]   prime_eff;
    logic [DIV_W-1:0]   dstep_full;

    logic               rd_en;
    logic [KEY_W-1:0]   rd_key;
    logic               rd_used;
    store_cmd_t         store_cmd;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg <= MODE_LINEAR;
            prime_reg      <= PRIME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROBE_MODE: probe_mode_reg <= cfg_data[MODE_W-1:0];
                REG_PRIME:      prime_reg      <= cfg_data[PRIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // hashing: key mod prime in the remainder unit, key mod SLOTS by reciprocal multiply
    assign prime_eff  = (prime_reg == '0) ? DIV_W'(1) : {1'b0, prime_reg};
    assign dstep_full = prime_eff - div_rem;
    assign rec_prod   = (2*KEY_W+1)'(key_reg) * (2*KEY_W+1)'(REC_M);
    assign home_full  = key_reg - KEY_W'(quot_reg * KEY_W'(SLOTS));

    oht_mod_unit u_mod_prime (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIV_DW'(s_tdata[KEY_W-1:0])),
        .divisor   (prime_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    // probe walk
    assign cur_slot = mod_add(home_reg, off_reg);
    assign issue    = (cnt_reg < SUM_W'(SLOTS));

    always_comb
    begin
        priority case (probe_mode_reg)
            MODE_QUAD:   term = inc_reg;
            MODE_DOUBLE: term = dstep_reg;
            default:     term = IDX_W'(ONE_MOD);
        endcase
    end

    always_comb
    begin
        hit = 1'b0;
        if (chk_reg)
        begin
            if (op_reg == OP_INSERT)
            begin
                hit = !rd_used;
            end
            else if (op_reg == OP_SEARCH || op_reg == OP_DELETE)
            begin
                hit = rd_used && (rd_key == key_reg);
            end
        end
    end

    oht_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (cur_slot),
        .rd_key  (rd_key),
        .rd_used (rd_used),
        .cmd     (store_cmd),
        .wr_addr (slot_q_reg),
        .wr_key  (key_reg)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (div_done)
                begin
                    state_next = (probe_mode_reg == MODE_DOUBLE) ? ST_STEP : ST_PROBE;
                end
            end
            ST_STEP:
            begin
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (hit || !issue)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        store_cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid;
            end
            ST_HASH:
            begin
            end
            ST_STEP:
            begin
            end
            ST_PROBE:
            begin
                rd_en = issue;
                if (hit)
                begin
                    store_cmd.wr_key   = (op_reg == OP_INSERT);
                    store_cmd.set_used = (op_reg == OP_INSERT);
                    store_cmd.clr_used = (op_reg == OP_DELETE);
                end
            end
            ST_RESULT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            chk_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_accept)
            begin
                cnt_reg <= '0;
                chk_reg <= 1'b0;
            end
            else if (state_reg == ST_PROBE)
            begin
                chk_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[KEY_W-1:0];
            off_reg <= '0;
            inc_reg <= IDX_W'(ONE_MOD);
        end
        if (state_reg == ST_HASH)
        begin
            quot_reg <= KEY_W'(rec_prod >> REC_SH);
            if (div_done)
            begin
                home_reg <= home_full[IDX_W-1:0];
            end
        end
        if (state_reg == ST_STEP)
        begin
            dstep_reg <= step_mod(dstep_full[PRIME_W-1:0]);
        end
        if (state_reg == ST_PROBE)
        begin
            if (issue)
            begin
                slot_q_reg <= cur_slot;
                off_reg    <= mod_add(off_reg, term);
                inc_reg    <= mod_add(inc_reg, IDX_W'(TWO_MOD));
            end
            if (hit || !issue)
            begin
                res_ok_reg   <= hit;
                res_slot_reg <= hit ? slot_q_reg : '0;
            end
        end
        if (out_load)
        begin
            m_tdata_reg <= SLOT_W'(res_slot_reg);
            m_tuser_reg <= res_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `OHT_ASSERT_NOW(a_store_write_in_probe,
        store_cmd.set_used || store_cmd.clr_used, state_reg == ST_PROBE,
        "slot store written outside the probe walk")
    `OHT_ASSERT_NOW(a_set_clr_exclusive,
        store_cmd.set_used, !store_cmd.clr_used,
        "slot set and cleared in the same cycle")
    `OHT_ASSERT_NOW(a_probe_count_bound,
        state_reg == ST_PROBE, cnt_reg <= SUM_W'(SLOTS),
        "probe count ran past the table size")
    `OHT_ASSERT_NOW(a_fail_slot_zero,
        m_tvalid_reg && !m_tuser_reg, m_tdata_reg == '0,
        "failed result carries a nonzero slot")
    `OHT_ASSERT_NEXT(a_accept_starts_hash,
        in_accept, state_reg == ST_HASH,
        "accepted beat did not start hashing")

endmodule

/* tb/tb_open_addressing_hash_table.sv */
// self-checking testbench for the open-addressing hash table
// needs oht_pkg and the open_addressing_hash_table rtl; keeps its own copy of the table
// and checks every result beat against it
module tb_open_addressing_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    import oht_pkg::*;

    localparam int NSLOT        = SLOTS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int SEG_ITEMS    = 150;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } lookup_t;

    typedef struct {
        lookup_t          res;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } pending_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SLOT_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow of the table and its configuration
    logic                tbl_used [NSLOT];
    logic [KEY_W-1:0]    tbl_key  [NSLOT];
    logic [MODE_W-1:0]   cur_mode;
    logic [PRIME_W-1:0]  cur_prime;

    pending_t lookups_due[$];

    int mismatches;
    int cycles;
    int items_sent;
    int results_seen;
    int hits_seen;
    int cfg_writes;
    int idle_on;
    int hold_cycles;
    int op_count [4];

    open_addressing_hash_table #(
        .SLOTS(NSLOT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, lookups_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int probe_slot(logic [KEY_W-1:0] key, int i);
        int unsigned home;
        int unsigned p;
        int unsigned step;
        home = key % NSLOT;
        case (cur_mode)
            MODE_QUAD:   step = i * i;
            MODE_DOUBLE:
            begin
                // a zero prime acts as one
                p    = (cur_prime == 0) ? 1 : cur_prime;
                step = i * (p - key % p);
            end
            default:     step = i;
        endcase
        return (home + step % NSLOT) % NSLOT;
    endfunction

    // applies one operation to the shadow table and returns the result it gives
    function automatic lookup_t table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        lookup_t r;
        int      s;
        r = '0;
        if (op == OP_INSERT)
        begin
            for (int i = 0; i < NSLOT && !r.hit; i++)
            begin
                s = probe_slot(key, i);
                if (!tbl_used[s])
                begin
                    tbl_used[s] = 1'b1;
                    tbl_key[s]  = key;
                    r.hit       = 1'b1;
                    r.slot      = s;
                end
            end
        end
        else if (op == OP_SEARCH || op == OP_DELETE)
        begin
            // empty slots do not end the walk
            for (int i = 0; i < NSLOT && !r.hit; i++)
            begin
                s = probe_slot(key, i);
                if (tbl_used[s] && tbl_key[s] == key)
                begin
                    if (op == OP_DELETE)
                        tbl_used[s] = 1'b0;
                    r.hit  = 1'b1;
                    r.slot = s;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        logic [31:0] w;
        w = $urandom;
        return w[KEY_W-1:0];
    endfunction

    // random key that lands on a given home slot
    function automatic logic [KEY_W-1:0] key_at(int home);
        logic [KEY_W-1:0] k;
        k = any_key();
        return k - k % NSLOT + home;
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        pending_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (lookups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: success %0d slot %0d",
                             m_tuser, m_tdata);
            end
            else
            begin
                due = lookups_due.pop_front();
                if (due.res.hit)
                    hits_seen++;
                if (m_tuser !== due.res.hit || m_tdata !== due.res.slot)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("op %0d key 0x%08h: expected success %0d slot %0d, got %0d %0d",
                                 due.op, due.key, due.res.hit, due.res.slot,
                                 m_tuser, m_tdata);
                end
            end
        end
    end

    // result sink: long hold when asked, random stalls when idling is on
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (idle_on != 0 && $urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // one operation beat; the shadow table is updated when the beat is taken
    task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        gap = (idle_on != 0) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, key};
        do
            @(posedge clk);
        while (!s_tready);
        lookups_due.push_back('{res: table_apply(op, key), op: op, key: key});
        items_sent++;
        op_count[op]++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_PROBE_MODE)
            cur_mode = val[MODE_W-1:0];
        else
            cur_prime = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_probe(input logic [MODE_W-1:0] mode, input logic [PRIME_W-1:0] prime);
        drain();
        write_reg(REG_PROBE_MODE, CFG_W'(mode));
        write_reg(REG_PRIME, prime);
    endtask

    // deletes every stored key; the probe rule must be the one the keys went in with
    task automatic clear_table();
        int s;
        s = 0;
        while (s < NSLOT)
        begin
            if (tbl_used[s])
            begin
                send_op(OP_DELETE, tbl_key[s]);
                s = 0;
            end
            else
                s++;
        end
    endtask

    // collisions, duplicates, full table, deletes that leave holes, unused op
    task automatic test_directed();
        send_op(OP_INSERT, 31'd0);
        send_op(OP_INSERT, 31'd8);
        send_op(OP_INSERT, 31'd16);
        send_op(OP_INSERT, 31'h7FFF_FFFF);
        send_op(OP_SEARCH, 31'd16);
        send_op(OP_DELETE, 31'd8);
        send_op(OP_SEARCH, 31'd16);
        send_op(OP_SEARCH, 31'd8);
        send_op(OP_UNUSED, 31'd16);
        send_op(OP_DELETE, 31'h7FFF_FFFF);
        for (int k = 24; k <= 64; k += 8)
            send_op(OP_INSERT, k);
        send_op(OP_INSERT, 31'd5);
        send_op(OP_SEARCH, 31'd64);
        send_op(OP_SEARCH, 31'h7FFF_FFFF);
        send_op(OP_DELETE, 31'd0);
        send_op(OP_INSERT, 31'd64);
        send_op(OP_DELETE, 31'd64);
        drain();
    endtask

    // each probe rule with colliding keys, the prime extremes and a step that repeats
    task automatic test_probe_modes();
        logic [MODE_W-1:0]  modes  [7] = '{MODE_QUAD, MODE_DOUBLE, MODE_DOUBLE, MODE_DOUBLE,
                                           MODE_DOUBLE, MODE_DOUBLE, MODE_UNUSED};
        logic [PRIME_W-1:0] primes [7] = '{8'd3, 8'd3, 8'd0, 8'd1, 8'd8, 8'd255, 8'd1};
        logic [KEY_W-1:0]   first;
        logic [KEY_W-1:0]   last;
        for (int n = 0; n < 7; n++)
        begin
            clear_table();
            set_probe(modes[n], primes[n]);
            first = key_at(0);
            send_op(OP_INSERT, first);
            for (int j = 0; j < 5; j++)
            begin
                last = key_at(0);
                send_op(OP_INSERT, last);
            end
            send_op(OP_SEARCH, last);
            send_op(OP_DELETE, first);
            send_op(OP_SEARCH, first);
        end
        drain();
    endtask

    // receiver holds off while operations keep coming, so the input stalls
    task automatic test_backpressure();
        set_probe(MODE_LINEAR, PRIME_RESET);
        idle_on     = 0;
        hold_cycles = 300;
        for (int j = 0; j < 12; j++)
            send_op((j % 3 == 0) ? OP_INSERT : OP_SEARCH, key_at(j % 2));
        drain();
    endtask

    task automatic test_random();
        logic [MODE_W-1:0]  seg_mode  [12] = '{MODE_LINEAR, MODE_QUAD, MODE_DOUBLE,
                                               MODE_DOUBLE, MODE_DOUBLE, MODE_DOUBLE,
                                               MODE_UNUSED, MODE_QUAD, MODE_DOUBLE,
                                               MODE_LINEAR, MODE_DOUBLE, MODE_DOUBLE};
        logic [PRIME_W-1:0] seg_prime [12] = '{8'd3, 8'd255, 8'd3, 8'd0, 8'd255, 8'd1,
                                               8'd0, 8'd1, 8'd16, 8'd128, 8'd0, 8'd0};
        logic [KEY_W-1:0]   pool [6];
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        int                 r;
        for (int n = 0; n < 12; n++)
        begin
            if (n >= 10)
                seg_prime[n] = $urandom_range(1, 255);
            set_probe(seg_mode[n], seg_prime[n]);
            idle_on = (n % 4 != 3);
            // small key pool on few home slots so probes collide
            for (int j = 0; j < 6; j++)
                pool[j] = ($urandom_range(3) == 0) ? any_key() : key_at($urandom_range(2));
            for (int j = 0; j < SEG_ITEMS; j++)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    op = OP_UNUSED;
                else if (r < 40)
                    op = OP_INSERT;
                else if (r < 67)
                    op = OP_SEARCH;
                else
                    op = OP_DELETE;
                key = ($urandom_range(99) < 80) ? pool[$urandom_range(5)] : any_key();
                send_op(op, key);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_INSERT;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PROBE_MODE;
        cfg_data    = '0;
        cycles      = 0;
        mismatches  = 0;
        items_sent  = 0;
        results_seen = 0;
        hits_seen   = 0;
        cfg_writes  = 0;
        idle_on     = 0;
        hold_cycles = 0;
        op_count    = '{default: 0};
        cur_mode    = MODE_LINEAR;
        cur_prime   = PRIME_RESET;
        for (int s = 0; s < NSLOT; s++)
        begin
            tbl_used[s] = 1'b0;
            tbl_key[s]  = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_probe_modes();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookups_due.size() != 0)
        begin
            $display("%0d results never arrived", lookups_due.size());
            mismatches += lookups_due.size();
        end
        $display("ran %0d operations (insert %0d, search %0d, delete %0d, unused %0d)",
                 items_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results checked, %0d successful, %0d register writes, %0d mismatches",
                 results_seen, hits_seen, cfg_writes, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/oht_pkg.sv
rtl/core/oht_mod_unit.sv
rtl/core/oht_store.sv
rtl/core/open_addressing_hash_table.sv
tb/tb_open_addressing_hash_table.sv
